FILE: hdl/tkr_pkg.sv
package tkr_pkg;

  localparam logic [1:0] REQ_OFFER = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  localparam logic [1:0] CMD_NONE  = 2'd0;
  localparam logic [1:0] CMD_OFFER = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  localparam int NUM_W     = 44;
  localparam int DIV_STEPS = 44;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [30:0]        link_id;
    logic [30:0]        from_node;
    logic [30:0]        to_node;
    logic [9:0]         period_index;
    logic signed [31:0] base_value;
    logic signed [31:0] load_value;
    logic [30:0]        volume;
    logic signed [31:0] given_ratio;
    logic [6:0]         read_index;
  } in_item_t;

  typedef struct packed {
    logic               inserted;
    logic [6:0]         position;
    logic               entry_valid;
    logic [30:0]        out_link;
    logic [30:0]        out_from;
    logic [30:0]        out_to;
    logic [9:0]         out_period;
    logic signed [31:0] out_base;
    logic signed [31:0] out_load;
    logic signed [31:0] out_ratio;
  } out_item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] ratio;
    logic [30:0]        link;
    logic [30:0]        from_node;
    logic [30:0]        to_node;
    logic [9:0]         period;
    logic signed [31:0] base;
    logic signed [31:0] load;
    logic [6:0]         read_index;
  } cmd_t;

endpackage

FILE: hdl/top_k_ratio_tracker.sv
// Top-K ratio tracker: keeps the LIST_DEPTH highest-ratio records, descending.
// Input queue side: present in_item_i with push; transfer when push & !full.
//   Request 0 offers a candidate, 1 reads one slot, 2 clears the list.
// Result queue side: result on out_item_o while empty is low; transfer when
//   pop & !empty. One result per request, in request order.
// Config: APB, volume floor register at address 0, pready tied high.
// Front end takes one request at a time; an offer with a zero given ratio and a
//   positive base value gets its ratio from a 44-step restoring divider.
// Back end: an insert runs a binary search of up to log2(LIST_DEPTH)+1 steps,
//   then moves each entry below the insert point down one slot, up to
//   LIST_DEPTH-1 entries, then writes the new record.
// A two-entry command queue lets the divider run while the list engine works.
// Reset zeroes the fill count and kept minimum at once; no clearing sweep.
// When the result queue is full the back end holds its result, the command
//   queue fills and full rises.
module top_k_ratio_tracker #(
  parameter int LIST_DEPTH  = 128,
  parameter int PERIOD_BITS = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  tkr_pkg::in_item_t  in_item_i,
  output logic               empty,
  input  logic               pop,
  output tkr_pkg::out_item_t out_item_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [30:0]        min_vol_q;
  tkr_pkg::cmd_t      f_cmd, b_cmd;
  logic               f_push, q_full, q_empty, b_pop;
  tkr_pkg::out_item_t b_res;
  logic               b_push, r_full;

  assign pready = 1'b1;
  assign prdata = (paddr == 3'd0) ? {1'b0, min_vol_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_vol_q <= '0;
    end else if (psel && penable && pwrite && paddr == 3'd0) begin
      min_vol_q <= pwdata[30:0];
    end
  end

  tkr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_push_i  (push),
    .in_full_o  (full),
    .in_item_i  (in_item_i),
    .min_vol_i  (min_vol_q),
    .cmd_o      (f_cmd),
    .cmd_push_o (f_push),
    .cmd_full_i (q_full)
  );

  tkr_fifo #(.WIDTH($bits(tkr_pkg::cmd_t)), .DEPTH(2)) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .wdata_i (f_cmd),
    .full_o  (q_full),
    .pop_i   (b_pop),
    .rdata_o (b_cmd),
    .empty_o (q_empty)
  );

  tkr_back #(.LIST_DEPTH(LIST_DEPTH), .PERIOD_BITS(PERIOD_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (b_cmd),
    .cmd_empty_i (q_empty),
    .cmd_pop_o   (b_pop),
    .res_o       (b_res),
    .res_push_o  (b_push),
    .res_full_i  (r_full)
  );

  tkr_fifo #(.WIDTH($bits(tkr_pkg::out_item_t)), .DEPTH(2)) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (b_push),
    .wdata_i (b_res),
    .full_o  (r_full),
    .pop_i   (pop),
    .rdata_o (out_item_o),
    .empty_o (empty)
  );

endmodule

FILE: hdl/tkr_ram.sv
module tkr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: hdl/tkr_fifo.sv
module tkr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] buf_q [DEPTH];
  logic [PW-1:0]    wp_q, wp_d, rp_q, rp_d;
  logic [PW:0]      cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == (PW+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = buf_q[rp_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wp_d = (wp_q == PW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
    end
    if (do_pop) begin
      rp_d = (rp_q == PW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wp_q] <= wdata_i;
    end
  end

endmodule

FILE: hdl/tkr_front.sv
module tkr_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_push_i,
  output logic             in_full_o,
  input  tkr_pkg::in_item_t in_item_i,
  input  logic [30:0]      min_vol_i,
  output tkr_pkg::cmd_t    cmd_o,
  output logic             cmd_push_o,
  input  logic             cmd_full_i
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_NUM  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_SAT  = 3'd3;
  localparam logic [2:0] S_PUSH = 3'd4;

  logic [2:0]                   state_q, state_d;
  tkr_pkg::in_item_t            item_q, item_d;
  tkr_pkg::cmd_t                cmd_q, cmd_d;
  logic [5:0]                   cnt_q, cnt_d;
  logic [31:0]                  rem_q, rem_d;
  logic [tkr_pkg::NUM_W-1:0]    quo_q, quo_d;
  logic                         neg_q, neg_d;
  logic signed [32:0]           diff;
  logic signed [tkr_pkg::NUM_W-1:0] num;
  logic [tkr_pkg::NUM_W-1:0]    mag;
  logic [31:0]                  trial;
  logic                         qbit;

  assign in_full_o = (state_q != S_IDLE);
  assign cmd_o     = cmd_q;

  always_comb begin
    diff = $signed({item_q.load_value[31], item_q.load_value})
         - $signed({item_q.base_value[31], item_q.base_value});
    num  = tkr_pkg::NUM_W'(diff) * 44'sd1000
         + $signed({13'd0, item_q.base_value[31:1]});
    mag  = num[tkr_pkg::NUM_W-1] ? tkr_pkg::NUM_W'(-num) : tkr_pkg::NUM_W'(num);
    trial = {rem_q[30:0], quo_q[tkr_pkg::NUM_W-1]};
    qbit  = (trial >= {1'b0, item_q.base_value[30:0]});
  end

  always_comb begin
    state_d    = state_q;
    item_d     = item_q;
    cmd_d      = cmd_q;
    cnt_d      = cnt_q;
    rem_d      = rem_q;
    quo_d      = quo_q;
    neg_d      = neg_q;
    cmd_push_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_push_i) begin
          item_d           = in_item_i;
          cmd_d.ratio      = in_item_i.given_ratio;
          cmd_d.link       = in_item_i.link_id;
          cmd_d.from_node  = in_item_i.from_node;
          cmd_d.to_node    = in_item_i.to_node;
          cmd_d.period     = in_item_i.period_index;
          cmd_d.base       = in_item_i.base_value;
          cmd_d.load       = in_item_i.load_value;
          cmd_d.read_index = in_item_i.read_index;
          state_d          = S_PUSH;
          case (in_item_i.req_type)
            tkr_pkg::REQ_OFFER: begin
              if (in_item_i.volume < min_vol_i) begin
                cmd_d.kind = tkr_pkg::CMD_NONE;
              end else begin
                cmd_d.kind = tkr_pkg::CMD_OFFER;
                if (in_item_i.given_ratio == '0 && !in_item_i.base_value[31]
                    && in_item_i.base_value != '0) begin
                  state_d = S_NUM;
                end
              end
            end
            tkr_pkg::REQ_READ:  cmd_d.kind = tkr_pkg::CMD_READ;
            tkr_pkg::REQ_CLEAR: cmd_d.kind = tkr_pkg::CMD_CLEAR;
            default:            cmd_d.kind = tkr_pkg::CMD_NONE;
          endcase
        end
      end
      S_NUM: begin
        quo_d   = mag;
        neg_d   = num[tkr_pkg::NUM_W-1];
        rem_d   = '0;
        cnt_d   = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        rem_d = qbit ? trial - {1'b0, item_q.base_value[30:0]} : trial;
        quo_d = {quo_q[tkr_pkg::NUM_W-2:0], qbit};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 6'(tkr_pkg::DIV_STEPS-1)) begin
          state_d = S_SAT;
        end
      end
      S_SAT: begin
        if (neg_q) begin
          cmd_d.ratio = (quo_q > 44'h0_8000_0000) ? 32'sh8000_0000 : -$signed(quo_q[31:0]);
        end else begin
          cmd_d.ratio = (quo_q > 44'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(quo_q[31:0]);
        end
        state_d = S_PUSH;
      end
      S_PUSH: begin
        cmd_push_o = 1'b1;
        if (!cmd_full_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    cmd_q  <= cmd_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    neg_q  <= neg_d;
  end

  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> cnt_q < 6'(tkr_pkg::DIV_STEPS))
    else $error("divider ran past its step count");

endmodule

FILE: hdl/tkr_back.sv
module tkr_back #(
  parameter int LIST_DEPTH  = 128,
  parameter int PERIOD_BITS = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tkr_pkg::cmd_t     cmd_i,
  input  logic              cmd_empty_i,
  output logic              cmd_pop_o,
  output tkr_pkg::out_item_t res_o,
  output logic              res_push_o,
  input  logic              res_full_i
);

  localparam int AW   = $clog2(LIST_DEPTH);
  localparam int EW   = 32 + 93 + PERIOD_BITS + 64;
  localparam int LAST = LIST_DEPTH - 1;

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_RDW  = 3'd1;
  localparam logic [2:0] B_SRCH = 3'd2;
  localparam logic [2:0] B_CMP  = 3'd3;
  localparam logic [2:0] B_SH   = 3'd4;
  localparam logic [2:0] B_INS  = 3'd5;
  localparam logic [2:0] B_OUT  = 3'd6;

  logic [2:0]              state_q, state_d;
  tkr_pkg::cmd_t           cmd_q, cmd_d;
  tkr_pkg::out_item_t      res_q, res_d;
  logic [AW:0]             lo_q, lo_d, hi_q, hi_d;
  logic [AW-1:0]           mid_q, mid_d, m_q, m_d;
  logic signed [31:0]      kmin_q, kmin_d;
  logic [AW:0]             fill_q, fill_d;
  logic                    rvalid_q;
  logic                    ram_we;
  logic [AW-1:0]           ram_waddr, ram_raddr;
  logic [EW-1:0]           ram_wdata, ram_rdata, ent, new_ent;
  logic [AW+1:0]           mid_sum;
  logic [PERIOD_BITS-1:0]  per_st;
  logic [9:0]              per_out;
  logic signed [31:0]      ent_ratio;

  tkr_ram #(.WIDTH(EW), .DEPTH(LIST_DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    for (int i = 0; i < PERIOD_BITS; i++) begin
      per_st[i] = (i < 10) ? cmd_q.period[i] : 1'b0;
    end
    for (int i = 0; i < 10; i++) begin
      per_out[i] = (i < PERIOD_BITS) ? ent[64 + i] : 1'b0;
    end
  end

  assign ent       = rvalid_q ? ram_rdata : '0;
  assign ent_ratio = $signed(ent[EW-1 -: 32]);
  assign new_ent   = {cmd_q.ratio, cmd_q.link, cmd_q.from_node, cmd_q.to_node, per_st,
                      cmd_q.base, cmd_q.load};
  assign mid_sum   = (AW+2)'(lo_q) + (AW+2)'(hi_q);
  assign res_o     = res_q;

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    res_d      = res_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    mid_d      = mid_q;
    m_d        = m_q;
    kmin_d     = kmin_q;
    fill_d     = fill_q;
    ram_we     = 1'b0;
    ram_waddr  = lo_q[AW-1:0];
    ram_wdata  = new_ent;
    ram_raddr  = mid_q;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    case (state_q)
      B_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          res_d     = '0;
          state_d   = B_OUT;
          case (cmd_i.kind)
            tkr_pkg::CMD_CLEAR: begin
              fill_d = '0;
              kmin_d = '0;
            end
            tkr_pkg::CMD_READ: begin
              res_d.position = cmd_i.read_index;
              ram_raddr      = AW'(cmd_i.read_index);
              if ({25'd0, cmd_i.read_index} < 32'(LIST_DEPTH)) begin
                state_d = B_RDW;
              end
            end
            tkr_pkg::CMD_OFFER: begin
              res_d.out_ratio = cmd_i.ratio;
              if (cmd_i.ratio > kmin_q) begin
                lo_d    = '0;
                hi_d    = (AW+1)'(LIST_DEPTH);
                state_d = B_SRCH;
              end
            end
            default: ;
          endcase
        end
      end
      B_RDW: begin
        res_d.entry_valid = (ent_ratio != '0);
        res_d.out_ratio   = ent_ratio;
        res_d.out_link    = ent[EW-33 -: 31];
        res_d.out_from    = ent[EW-64 -: 31];
        res_d.out_to      = ent[EW-95 -: 31];
        res_d.out_period  = per_out;
        res_d.out_base    = $signed(ent[63:32]);
        res_d.out_load    = $signed(ent[31:0]);
        state_d           = B_OUT;
      end
      B_SRCH: begin
        if (lo_q < hi_q) begin
          ram_raddr = mid_sum[AW:1];
          mid_d     = mid_sum[AW:1];
          state_d   = B_CMP;
        end else if (lo_q == (AW+1)'(LIST_DEPTH)) begin
          state_d = B_OUT;
        end else if (lo_q < fill_q && lo_q[AW-1:0] != AW'(LAST)) begin
          ram_raddr = AW'(LAST - 1);
          m_d       = AW'(LAST);
          state_d   = B_SH;
        end else begin
          state_d = B_INS;
        end
      end
      B_CMP: begin
        if (cmd_q.ratio > ent_ratio) begin
          hi_d = {1'b0, mid_q};
        end else begin
          lo_d = (AW+1)'(mid_q) + 1'b1;
        end
        state_d = B_SRCH;
      end
      B_SH: begin
        ram_we          = 1'b1;
        ram_waddr       = m_q;
        ram_wdata       = ent;
        if (m_q == AW'(LAST)) begin
          kmin_d = ent_ratio;
        end
        if (m_q - 1'b1 == lo_q[AW-1:0]) begin
          state_d = B_INS;
        end else begin
          ram_raddr = m_q - AW'(2);
          m_d       = m_q - 1'b1;
        end
      end
      B_INS: begin
        ram_we                  = 1'b1;
        if (fill_q != (AW+1)'(LIST_DEPTH)) begin
          fill_d = fill_q + 1'b1;
        end
        res_d.inserted          = 1'b1;
        res_d.position          = 7'(lo_q);
        state_d                 = B_OUT;
      end
      B_OUT: begin
        res_push_o = 1'b1;
        if (!res_full_i) begin
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= B_IDLE;
      kmin_q   <= '0;
      fill_q   <= '0;
      rvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      kmin_q   <= kmin_d;
      fill_q   <= fill_d;
      rvalid_q <= ({1'b0, ram_raddr} < fill_q);
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    res_q <= res_d;
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    mid_q <= mid_d;
    m_q   <= m_d;
  end

  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= (AW+1)'(LIST_DEPTH))
    else $error("fill count beyond list depth");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_IDLE && !cmd_empty_i && cmd_i.kind == tkr_pkg::CMD_CLEAR |=> fill_q == '0)
    else $error("clear left slots occupied");

  a_kmin: assert property (@(posedge clk_i) disable iff (!rst_ni) !kmin_q[31])
    else $error("kept minimum went negative");

endmodule
